// ===== rtl/mips_subset_execute_step_core_macros.svh =====
// Assertion macros used by the port-level checker of the execute step core.
`ifndef MIPS_SUBSET_EXECUTE_STEP_CORE_MACROS_SVH
`define MIPS_SUBSET_EXECUTE_STEP_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MIPSX_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mipsx: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define MIPSX_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mipsx: next-cycle check failed");

`endif

// ===== rtl/mipsx_pkg.sv =====
// ----------------------------------------------------------------------------
// mipsx_pkg
// Types and encodings for the MIPS integer subset execute step core.
// ----------------------------------------------------------------------------
package mipsx_pkg;

  typedef logic [31:0] word_t;
  typedef logic [4:0]  reg_idx_t;
  typedef logic [1:0]  status_t;

  // opcodes
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_ANDI    = 6'h0C;

  // SPECIAL funct codes
  localparam logic [5:0] FN_SLL     = 6'h00;
  localparam logic [5:0] FN_SRL     = 6'h02;
  localparam logic [5:0] FN_SRA     = 6'h03;
  localparam logic [5:0] FN_SLLV    = 6'h04;
  localparam logic [5:0] FN_SRLV    = 6'h06;
  localparam logic [5:0] FN_SRAV    = 6'h07;
  localparam logic [5:0] FN_JR      = 6'h08;
  localparam logic [5:0] FN_SYSCALL = 6'h0C;
  localparam logic [5:0] FN_ADD     = 6'h20;
  localparam logic [5:0] FN_ADDU    = 6'h21;
  localparam logic [5:0] FN_SUB     = 6'h22;
  localparam logic [5:0] FN_SUBU    = 6'h23;
  localparam logic [5:0] FN_AND     = 6'h24;
  localparam logic [5:0] FN_OR      = 6'h25;
  localparam logic [5:0] FN_XOR     = 6'h26;
  localparam logic [5:0] FN_NOR     = 6'h27;

  // system call codes (selected by v0)
  localparam word_t SYS_PRINT_INT = 32'h0000_0001;
  localparam word_t SYS_READ_INT  = 32'h0000_0005;
  localparam word_t SYS_EXIT      = 32'h0000_000A;

  // fixed registers
  localparam reg_idx_t REG_ZERO = 5'd0;
  localparam reg_idx_t REG_V0   = 5'd2;
  localparam reg_idx_t REG_A0   = 5'd4;
  localparam reg_idx_t REG_RA   = 5'd31;

  localparam word_t PC_REGION_MASK = 32'hF000_0000;

  // result status
  localparam status_t STATUS_OK          = 2'd0;
  localparam status_t STATUS_UNSUPPORTED = 2'd1;
  localparam status_t STATUS_BAD_SYSCALL = 2'd2;
  localparam status_t STATUS_HALTED      = 2'd3;

endpackage

// ===== rtl/mips_subset_execute_step_core.sv =====
// Accepted instructions pass the execute stage and output registers. Throughput: one
// instruction per cycle while out_stall allows; the register file read is issued at
// acceptance and the preceding instruction's write is forwarded into the execute stage.
// Reset (rst_n low, synchronous) clears pc, halted, the pipeline valids and the
// register file valid bits, so every register reads zero afterwards.
// ----------------------------------------------------------------------------
// mips_subset_execute_step_core
// Execute stage for a MIPS32 integer subset: ALU, shifts, jumps and system calls
// against a 32-entry register file and a word-indexed program counter.
// ----------------------------------------------------------------------------
module mips_subset_execute_step_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_instr_word,
  input  logic [31:0] in_read_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_next_pc,
  output logic [1:0]  out_status,
  output logic        out_print_valid,
  output logic [31:0] out_print_value,
  output logic        out_exit_now
);

  // register file storage and valid bits
  mipsx_pkg::word_t    rf_mem [32];
  logic [31:0]         rf_vld_r;
  mipsx_pkg::word_t    rd_a_r, rd_b_r;
  logic                vld_a_r, vld_b_r;

  // shadow copies of v0 and a0
  mipsx_pkg::word_t    reg2_r, reg4_r;

  // execute stage
  logic                exe_vld_r;
  mipsx_pkg::word_t    exe_instr_r;
  mipsx_pkg::word_t    exe_rv_r;

  // forward of the write that committed at this transaction's acceptance
  logic                fwd_en_r;
  mipsx_pkg::reg_idx_t fwd_addr_r;
  mipsx_pkg::word_t    fwd_data_r;

  // architectural state
  mipsx_pkg::word_t    pc_r, pc_nxt;
  logic                halted_r, halted_nxt;

  // output register
  logic                out_valid_r;
  mipsx_pkg::word_t    out_next_pc_r;
  mipsx_pkg::status_t  out_status_r;
  logic                out_print_valid_r;
  mipsx_pkg::word_t    out_print_value_r;
  logic                out_exit_now_r;

  logic                advance, in_accept;

  logic [5:0]          opc, fn;
  mipsx_pkg::reg_idx_t rs, rt, rd, shamt;
  logic [15:0]         imm;
  mipsx_pkg::word_t    simm, op_a, op_b;

  logic                wb_en, wb_commit;
  mipsx_pkg::reg_idx_t wb_addr;
  mipsx_pkg::word_t    wb_data;
  mipsx_pkg::status_t  status_c;
  logic                pv_c, ex_c;
  mipsx_pkg::word_t    pval_c;

  assign advance   = exe_vld_r && (!out_valid_r || !out_stall);
  assign in_stall  = exe_vld_r && !advance;
  assign in_accept = in_valid && !in_stall;

  assign opc   = exe_instr_r[31:26];
  assign rs    = exe_instr_r[25:21];
  assign rt    = exe_instr_r[20:16];
  assign rd    = exe_instr_r[15:11];
  assign shamt = exe_instr_r[10:6];
  assign fn    = exe_instr_r[5:0];
  assign imm   = exe_instr_r[15:0];
  assign simm  = {{16{imm[15]}}, imm};

  // register zero is never written, so its valid bit stays clear and it reads zero
  assign op_a = (fwd_en_r && fwd_addr_r == rs) ? fwd_data_r : (vld_a_r ? rd_a_r : '0);
  assign op_b = (fwd_en_r && fwd_addr_r == rt) ? fwd_data_r : (vld_b_r ? rd_b_r : '0);

  always_comb begin
    wb_en      = 1'b0;
    wb_addr    = rd;
    wb_data    = '0;
    pc_nxt     = pc_r + 32'd1;
    halted_nxt = halted_r;
    status_c   = mipsx_pkg::STATUS_OK;
    pv_c       = 1'b0;
    pval_c     = '0;
    ex_c       = 1'b0;
    if (halted_r) begin
      pc_nxt   = pc_r;
      status_c = mipsx_pkg::STATUS_HALTED;
    end else begin
      case (opc)
        mipsx_pkg::OP_SPECIAL: begin
          case (fn)
            mipsx_pkg::FN_SLL: begin
              wb_en   = 1'b1;
              wb_data = op_b << shamt;
            end
            mipsx_pkg::FN_SRL: begin
              wb_en   = 1'b1;
              wb_data = op_b >> shamt;
            end
            mipsx_pkg::FN_SRA: begin
              wb_en   = 1'b1;
              wb_data = $unsigned($signed(op_b) >>> shamt);
            end
            mipsx_pkg::FN_SLLV: begin
              wb_en   = 1'b1;
              wb_data = op_b << op_a[4:0];
            end
            mipsx_pkg::FN_SRLV: begin
              wb_en   = 1'b1;
              wb_data = op_b >> op_a[4:0];
            end
            mipsx_pkg::FN_SRAV: begin
              wb_en   = 1'b1;
              wb_data = $unsigned($signed(op_b) >>> op_a[4:0]);
            end
            mipsx_pkg::FN_JR: begin
              pc_nxt = op_a;
            end
            mipsx_pkg::FN_SYSCALL: begin
              if (reg2_r == mipsx_pkg::SYS_PRINT_INT) begin
                pv_c   = 1'b1;
                pval_c = reg4_r;
              end else if (reg2_r == mipsx_pkg::SYS_READ_INT) begin
                wb_en   = 1'b1;
                wb_addr = mipsx_pkg::REG_V0;
                wb_data = exe_rv_r;
              end else if (reg2_r == mipsx_pkg::SYS_EXIT) begin
                halted_nxt = 1'b1;
                ex_c       = 1'b1;
              end else begin
                status_c = mipsx_pkg::STATUS_BAD_SYSCALL;
              end
            end
            mipsx_pkg::FN_ADD, mipsx_pkg::FN_ADDU: begin
              wb_en   = 1'b1;
              wb_data = op_a + op_b;
            end
            mipsx_pkg::FN_SUB, mipsx_pkg::FN_SUBU: begin
              wb_en   = 1'b1;
              wb_data = op_a - op_b;
            end
            mipsx_pkg::FN_AND: begin
              wb_en   = 1'b1;
              wb_data = op_a & op_b;
            end
            mipsx_pkg::FN_OR: begin
              wb_en   = 1'b1;
              wb_data = op_a | op_b;
            end
            mipsx_pkg::FN_XOR: begin
              wb_en   = 1'b1;
              wb_data = op_a ^ op_b;
            end
            mipsx_pkg::FN_NOR: begin
              wb_en   = 1'b1;
              wb_data = ~(op_a | op_b);
            end
            default: begin
              status_c = mipsx_pkg::STATUS_UNSUPPORTED;
            end
          endcase
        end
        mipsx_pkg::OP_J: begin
          pc_nxt = (pc_r & mipsx_pkg::PC_REGION_MASK) | {6'd0, exe_instr_r[25:0]};
        end
        mipsx_pkg::OP_JAL: begin
          wb_en   = 1'b1;
          wb_addr = mipsx_pkg::REG_RA;
          wb_data = pc_r + 32'd1;
          pc_nxt  = (pc_r & mipsx_pkg::PC_REGION_MASK) | {6'd0, exe_instr_r[25:0]};
        end
        mipsx_pkg::OP_ADDI, mipsx_pkg::OP_ADDIU: begin
          wb_en   = 1'b1;
          wb_addr = rt;
          wb_data = op_a + simm;
        end
        mipsx_pkg::OP_ANDI: begin
          wb_en   = 1'b1;
          wb_addr = rt;
          wb_data = op_a & {16'd0, imm};
        end
        default: begin
          status_c = mipsx_pkg::STATUS_UNSUPPORTED;
        end
      endcase
    end
  end

  assign wb_commit = advance && wb_en && (wb_addr != mipsx_pkg::REG_ZERO);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exe_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
      pc_r        <= '0;
      halted_r    <= 1'b0;
      rf_vld_r    <= '0;
      reg2_r      <= '0;
      reg4_r      <= '0;
      fwd_en_r    <= 1'b0;
    end else begin
      if (in_accept) begin
        exe_vld_r <= 1'b1;
      end else if (advance) begin
        exe_vld_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        pc_r        <= pc_nxt;
        halted_r    <= halted_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (wb_commit) begin
        rf_vld_r[wb_addr] <= 1'b1;
        if (wb_addr == mipsx_pkg::REG_V0) begin
          reg2_r <= wb_data;
        end
        if (wb_addr == mipsx_pkg::REG_A0) begin
          reg4_r <= wb_data;
        end
      end
      if (in_accept) begin
        fwd_en_r <= wb_commit;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      exe_instr_r <= in_instr_word;
      exe_rv_r    <= in_read_value;
      fwd_addr_r  <= wb_addr;
      fwd_data_r  <= wb_data;
      vld_a_r     <= rf_vld_r[in_instr_word[25:21]];
      vld_b_r     <= rf_vld_r[in_instr_word[20:16]];
    end
    if (advance) begin
      out_next_pc_r     <= pc_nxt;
      out_status_r      <= status_c;
      out_print_valid_r <= pv_c;
      out_print_value_r <= pval_c;
      out_exit_now_r    <= ex_c;
    end
  end

  // register file: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wb_commit) begin
      rf_mem[wb_addr] <= wb_data;
    end
    if (in_accept) begin
      rd_a_r <= rf_mem[in_instr_word[25:21]];
      rd_b_r <= rf_mem[in_instr_word[20:16]];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_next_pc     = out_next_pc_r;
  assign out_status      = out_status_r;
  assign out_print_valid = out_print_valid_r;
  assign out_print_value = out_print_value_r;
  assign out_exit_now    = out_exit_now_r;

endmodule

// ===== rtl/mipsx_checker.sv =====
// ----------------------------------------------------------------------------
// mipsx_checker
// Port-level checks on the result channel of the execute step core.
// ----------------------------------------------------------------------------
`include "mips_subset_execute_step_core_macros.svh"

module mipsx_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_next_pc,
  input logic [1:0]  out_status,
  input logic        out_print_valid,
  input logic [31:0] out_print_value,
  input logic        out_exit_now
);

  `MIPSX_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_next_pc) && $stable(out_status))
  `MIPSX_ASSERT_NOW(a_halted_quiet, out_valid && out_status == mipsx_pkg::STATUS_HALTED, !out_print_valid && !out_exit_now && out_print_value == 32'd0)
  `MIPSX_ASSERT_NOW(a_print_exit_excl, out_valid, !(out_print_valid && out_exit_now))
  `MIPSX_ASSERT_NOW(a_flags_ok_status, out_valid && (out_print_valid || out_exit_now), out_status == mipsx_pkg::STATUS_OK)
  `MIPSX_ASSERT_NOW(a_print_value_zero, out_valid && !out_print_valid, out_print_value == 32'd0)

endmodule

bind mips_subset_execute_step_core mipsx_checker u_mipsx_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_next_pc     (out_next_pc),
  .out_status      (out_status),
  .out_print_valid (out_print_valid),
  .out_print_value (out_print_value),
  .out_exit_now    (out_exit_now)
);

// ===== tb/mipsx_exec_checker.sv =====
// ----------------------------------------------------------------------------
// mipsx_exec_checker
// Watches both channels of the execute step core. Every accepted instruction
// is run through an architectural model (register file, pc, halt flag) and
// the predicted retirement is queued; every accepted result is compared,
// field by field, against the oldest queued retirement.
// ----------------------------------------------------------------------------
module mipsx_exec_checker
  import mipsx_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [31:0] in_instr_word,
  input  logic [31:0] in_read_value,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_next_pc,
  input  logic [1:0]  out_status,
  input  logic        out_print_valid,
  input  logic [31:0] out_print_value,
  input  logic        out_exit_now,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    word_t   next_pc;
    status_t status;
    logic    print_valid;
    word_t   print_value;
    logic    exit_now;
  } retire_t;

  word_t   arch_regs [32];
  word_t   arch_pc;
  logic    arch_halted;
  retire_t retire_q [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic void write_reg(reg_idx_t idx, word_t value);
    if (idx != REG_ZERO) arch_regs[idx] = value;
  endfunction

  function automatic retire_t execute_instr(word_t w, word_t rv);
    retire_t    r;
    logic [5:0] opc;
    logic [5:0] fn;
    reg_idx_t   rs;
    reg_idx_t   rt;
    reg_idx_t   rd;
    logic [4:0] sh;
    word_t      a;
    word_t      b;
    word_t      simm;
    word_t      npc;
    word_t      jtarget;
    r = '0;
    if (arch_halted) begin
      r.next_pc = arch_pc;
      r.status  = STATUS_HALTED;
      return r;
    end
    opc     = w[31:26];
    rs      = w[25:21];
    rt      = w[20:16];
    rd      = w[15:11];
    sh      = w[10:6];
    fn      = w[5:0];
    simm    = {{16{w[15]}}, w[15:0]};
    a       = arch_regs[rs];
    b       = arch_regs[rt];
    npc     = arch_pc + 32'd1;
    jtarget = (arch_pc & PC_REGION_MASK) | {6'b0, w[25:0]};
    r.status = STATUS_OK;
    case (opc)
      OP_SPECIAL: begin
        case (fn)
          FN_SLL:  write_reg(rd, b << sh);
          FN_SRL:  write_reg(rd, b >> sh);
          FN_SRA:  write_reg(rd, word_t'($signed(b) >>> sh));
          FN_SLLV: write_reg(rd, b << a[4:0]);
          FN_SRLV: write_reg(rd, b >> a[4:0]);
          FN_SRAV: write_reg(rd, word_t'($signed(b) >>> a[4:0]));
          FN_JR:   npc = a;
          FN_SYSCALL: begin
            if (arch_regs[REG_V0] == SYS_PRINT_INT) begin
              r.print_valid = 1'b1;
              r.print_value = arch_regs[REG_A0];
            end else if (arch_regs[REG_V0] == SYS_READ_INT) begin
              write_reg(REG_V0, rv);
            end else if (arch_regs[REG_V0] == SYS_EXIT) begin
              arch_halted = 1'b1;
              r.exit_now  = 1'b1;
            end else begin
              r.status = STATUS_BAD_SYSCALL;
            end
          end
          FN_ADD, FN_ADDU: write_reg(rd, a + b);
          FN_SUB, FN_SUBU: write_reg(rd, a - b);
          FN_AND:  write_reg(rd, a & b);
          FN_OR:   write_reg(rd, a | b);
          FN_XOR:  write_reg(rd, a ^ b);
          FN_NOR:  write_reg(rd, ~(a | b));
          default: r.status = STATUS_UNSUPPORTED;
        endcase
      end
      OP_J: npc = jtarget;
      OP_JAL: begin
        write_reg(REG_RA, arch_pc + 32'd1);
        npc = jtarget;
      end
      OP_ADDI, OP_ADDIU: write_reg(rt, a + simm);
      OP_ANDI: write_reg(rt, a & {16'h0, w[15:0]});
      default: r.status = STATUS_UNSUPPORTED;
    endcase
    arch_pc   = npc;
    r.next_pc = npc;
    return r;
  endfunction

  function automatic void check_field(string fname, word_t want, word_t got);
    if (want !== got) begin
      fail_count++;
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, fname, want, got);
    end
  endfunction

  always @(posedge clk) begin
    retire_t want;
    if (!rst_n) begin
      foreach (arch_regs[i]) arch_regs[i] = '0;
      arch_pc     = '0;
      arch_halted = 1'b0;
      retire_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (retire_q.size() == 0) begin
          fail_count++;
          $display("%0t ns: unexpected transaction, expected none, actual next_pc %h status %0d",
                   $time, out_next_pc, out_status);
        end else begin
          want = retire_q.pop_front();
          check_field("next_pc", want.next_pc, out_next_pc);
          check_field("status", word_t'(want.status), word_t'(out_status));
          check_field("print_valid", word_t'(want.print_valid), word_t'(out_print_valid));
          check_field("print_value", want.print_value, out_print_value);
          check_field("exit_now", word_t'(want.exit_now), word_t'(out_exit_now));
        end
      end
      if (in_valid && !in_stall)
        retire_q.push_back(execute_instr(in_instr_word, in_read_value));
    end
    pending = retire_q.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the execute step core: a directed instruction
// sequence covering immediates, shifts, ALU ops, jumps, pc wrap and system
// calls, then random instruction streams with random gaps and stalls on
// both channels, a long output hold-off, and a final exit followed by
// instructions that must be ignored.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mipsx_pkg::*;

  localparam logic [5:0] OP_UNUSED = 6'h3F;
  localparam logic [5:0] FN_UNUSED = 6'h3F;
  localparam int RANDOM_ITEMS = 800;
  localparam int FLOOD_START  = 300;
  localparam int FLOOD_LEN    = 80;
  localparam int DRAIN_AT     = 550;
  localparam int HOLD_CYCLES  = 100;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_instr_word;
  logic [31:0] in_read_value;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_next_pc;
  logic [1:0]  out_status;
  logic        out_print_valid;
  logic [31:0] out_print_value;
  logic        out_exit_now;
  int          fail_count;
  int          pending;

  bit sender_fast;
  bit receiver_fast;
  bit flood;

  logic [5:0] alu_fns [14] = '{FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV,
                               FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_AND, FN_OR,
                               FN_XOR, FN_NOR};

  mips_subset_execute_step_core dut (.*);

  mipsx_exec_checker checker_i (.*);

  initial clk = 1'b0;
  always #4 clk = ~clk;

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic word_t enc_r(logic [5:0] fn, reg_idx_t rs, reg_idx_t rt,
                                  reg_idx_t rd, logic [4:0] sh);
    return {OP_SPECIAL, rs, rt, rd, sh, fn};
  endfunction

  function automatic word_t enc_i(logic [5:0] op, reg_idx_t rs, reg_idx_t rt,
                                  logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  function automatic word_t enc_j(logic [5:0] op, logic [25:0] tgt);
    return {op, tgt};
  endfunction

  // half the picks land in the low registers to create back-to-back dependencies
  function automatic reg_idx_t pick_reg();
    if ($urandom_range(0, 1)) return reg_idx_t'($urandom_range(0, 7));
    return reg_idx_t'($urandom_range(0, 31));
  endfunction

  function automatic logic [15:0] pick_imm();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'h7FFF;
      2: return 16'h8000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_instr(input word_t w, input word_t rv);
    int gap;
    gap = sender_fast ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    in_instr_word <= w;
    in_read_value <= rv;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic send_syscall(input word_t code, input word_t rv);
    send_instr(enc_i(OP_ADDIU, REG_ZERO, REG_V0, code[15:0]), $urandom);
    send_instr(enc_r(FN_SYSCALL, REG_ZERO, REG_ZERO, REG_ZERO, 5'd0), rv);
  endtask

  // receiver: random stall before each result, one long hold-off on request
  initial begin
    int n;
    int results;
    out_stall = 1'b0;
    results   = 0;
    @(posedge rst_n);
    forever begin
      if (results % 40 == 0) receiver_fast = ($urandom_range(0, 3) == 0);
      n = receiver_fast ? 0 : $urandom_range(0, 10);
      if (flood) begin
        n     = HOLD_CYCLES;
        flood = 1'b0;
      end
      repeat (n) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      results++;
    end
  end

  initial begin
    int          n;
    int          sel;
    word_t       code;
    word_t       w;
    logic [5:0]  fn;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_instr_word = '0;
    in_read_value = '0;
    sender_fast   = 1'b0;
    flood         = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // directed: immediates, ALU, shifts, register zero, unsupported codes
    send_instr(32'h0000_0000, 32'h0000_0000);
    send_instr(enc_i(OP_ADDIU, REG_ZERO, 5'd1, 16'h7FFF), 32'hFFFF_FFFF);
    send_instr(enc_i(OP_ADDI, REG_ZERO, 5'd3, 16'h8000), $urandom);
    send_instr(enc_i(OP_ANDI, 5'd3, 5'd5, 16'hFFFF), $urandom);
    send_instr(enc_r(FN_NOR, REG_ZERO, REG_ZERO, 5'd6, 5'd0), $urandom);
    send_instr(enc_r(FN_ADD, 5'd6, 5'd6, 5'd7, 5'd0), $urandom);
    send_instr(enc_r(FN_SUB, REG_ZERO, 5'd1, 5'd4, 5'd0), $urandom);
    send_instr(enc_r(FN_SLL, REG_ZERO, 5'd6, 5'd8, 5'd31), $urandom);
    send_instr(enc_r(FN_SRL, REG_ZERO, 5'd6, 5'd9, 5'd31), $urandom);
    send_instr(enc_r(FN_SRA, REG_ZERO, 5'd8, 5'd10, 5'd31), $urandom);
    send_instr(enc_r(FN_SLLV, 5'd6, 5'd6, 5'd11, 5'd0), $urandom);
    send_instr(enc_r(FN_SRAV, 5'd4, 5'd8, 5'd12, 5'd0), $urandom);
    send_instr(enc_i(OP_ADDIU, 5'd1, REG_ZERO, 16'h0005), $urandom);
    send_instr(enc_r(FN_ADDU, REG_ZERO, 5'd1, 5'd13, 5'd0), $urandom);
    send_instr({OP_UNUSED, 26'h3FF_FFFF}, $urandom);
    send_instr(enc_r(FN_UNUSED, 5'd31, 5'd31, 5'd31, 5'd31), $urandom);
    // system calls: print, read, then an invalid code left in v0 by the read
    send_syscall(SYS_PRINT_INT, $urandom);
    send_syscall(SYS_READ_INT, 32'hFFFF_FFFF);
    send_instr(enc_r(FN_SYSCALL, REG_ZERO, REG_ZERO, REG_ZERO, 5'd0), $urandom);
    // jumps at the top of the address space and pc wrap
    send_instr(enc_r(FN_JR, 5'd6, REG_ZERO, REG_ZERO, 5'd0), $urandom);
    send_instr(enc_j(OP_JAL, 26'h3FF_FFFF), $urandom);
    send_instr(enc_r(FN_JR, 5'd6, REG_ZERO, REG_ZERO, 5'd0), $urandom);
    send_instr(enc_r(FN_OR, 5'd31, 5'd1, 5'd14, 5'd0), $urandom);
    send_instr(enc_j(OP_J, 26'h000_0000), $urandom);
    drain();

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) sender_fast = ($urandom_range(0, 3) == 0);
      if (n == FLOOD_START) flood = 1'b1;
      if (n >= FLOOD_START && n < FLOOD_START + FLOOD_LEN) sender_fast = 1'b1;
      if (n == DRAIN_AT) drain();
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
        case ($urandom_range(0, 2))
          0: code = SYS_PRINT_INT;
          1: code = SYS_READ_INT;
          default: begin
            code = {16'h0, 16'($urandom)};
            if (code == SYS_EXIT) code = SYS_EXIT + 32'd1;
          end
        endcase
        send_syscall(code, $urandom);
      end else if (sel < 58) begin
        fn = alu_fns[$urandom_range(0, 13)];
        send_instr(enc_r(fn, pick_reg(), pick_reg(), pick_reg(), 5'($urandom)), $urandom);
      end else if (sel < 78) begin
        case ($urandom_range(0, 2))
          0: fn = OP_ADDI;
          1: fn = OP_ADDIU;
          default: fn = OP_ANDI;
        endcase
        send_instr(enc_i(fn, pick_reg(), pick_reg(), pick_imm()), $urandom);
      end else if (sel < 88) begin
        case ($urandom_range(0, 2))
          0: w = enc_j(OP_J, 26'($urandom));
          1: w = enc_j(OP_JAL, 26'($urandom));
          default: w = enc_r(FN_JR, pick_reg(), 5'($urandom), 5'($urandom), 5'($urandom));
        endcase
        send_instr(w, $urandom);
      end else begin
        // raw words; a stray system call would be able to halt the core early
        w = $urandom;
        if (w[31:26] == OP_SPECIAL && w[5:0] == FN_SYSCALL) w[0] = ~w[0];
        send_instr(w, $urandom);
      end
    end

    // exit, then the core must ignore everything
    send_syscall(SYS_EXIT, $urandom);
    repeat (6) send_instr($urandom, $urandom);
    drain();
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== mips_subset_execute_step_core.f =====
+incdir+rtl
rtl/mipsx_pkg.sv
rtl/mips_subset_execute_step_core.sv
rtl/mipsx_checker.sv
tb/mipsx_exec_checker.sv
tb/tb_top.sv
